/* design/xrvg_pkg.sv */
package xrvg_pkg;

   localparam logic [31:0] ZERO_SEED_SUBST = 32'h6d2b79f5;
   localparam int unsigned SHIFT_A = 13;
   localparam int unsigned SHIFT_B = 17;
   localparam int unsigned SHIFT_C = 5;
   localparam int unsigned TOP_BIT = 31;
   localparam int unsigned ITER_COUNT = 32;

   typedef enum logic [1:0] {
      KIND_BOOL  = 2'd0,
      KIND_INT   = 2'd1,
      KIND_FIXED = 2'd2,
      KIND_PAIR  = 2'd3
   } kind_type;

   typedef enum logic {
      OP_MOD = 1'b0,
      OP_MUL = 1'b1
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   function automatic logic [31:0] xorshift_step(input logic [31:0] cur);
      logic [31:0] x;
      x = (cur == 32'd0) ? ZERO_SEED_SUBST : cur;
      x = x ^ (x << SHIFT_A);
      x = x ^ (x >> SHIFT_B);
      x = x ^ (x << SHIFT_C);
      return x;
   endfunction

   function automatic logic [31:0] load_seed(input logic [31:0] seed);
      return (seed == 32'd0) ? ZERO_SEED_SUBST : seed;
   endfunction

endpackage

/* design/xorshift_ranged_value_generator.sv */
// Ranged random value generator around a 32-bit xorshift (13, 17, 5). Each request
// draws and maps the draw to a boolean (top bit), an integer in [lower, upper]
// (draw modulo the inclusive span) or a signed fixed-point value
// lower + ((upper - lower) * draw) >> 32; a pair kind produces x then y. An empty
// range (upper <= lower) returns lower without a draw, except for a boolean. One
// request is worked at a time. An integer or fixed-point value is worked out in
// the 32 steps of the shared add/subtract unit that does both the restoring
// remainder and the shift-add multiply. A finished result waits in an output
// register while the next request is accepted. The seed register at byte
// address 0 is loaded into the generator only by a request with restart set.
module xorshift_ranged_value_generator
   import xrvg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // lower_bound, upper_bound
   input  logic [2:0]  req_tuser,   // req_type, restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // value_first, value_second
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DRAW = 4'b0010,
      S_WAIT = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type       state_ff, state_in;
   kind_type        kind_ff, kind_in;
   logic            slot_ff, slot_in;
   logic [31:0]     gen_ff, gen_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [31:0]     lo_ff, lo_in;
   logic [31:0]     hi_ff, hi_in;
   logic [31:0]     first_ff, first_in;
   logic [31:0]     second_ff, second_in;
   logic [63:0]     rsp_data_ff, rsp_data_in;

   logic [31:0]     seed_value;
   logic [31:0]     gen_next;
   logic [31:0]     diff;
   logic            empty;
   logic            finish;
   logic [31:0]     val;
   logic            req_accept;
   logic            out_free;
   unit_cmd_type    unit_cmd;
   unit_status_type unit_status;
   logic [31:0]     unit_opa;
   logic [32:0]     unit_opb;
   logic [31:0]     unit_result;

   xrvg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .seed_value  (seed_value)
   );

   xrvg_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .cmd    (unit_cmd),
      .opa    (unit_opa),
      .opb    (unit_opb),
      .status (unit_status),
      .result (unit_result)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign gen_next   = xorshift_step(gen_ff);
   assign diff       = hi_ff - lo_ff;
   assign empty      = ($signed(hi_ff) <= $signed(lo_ff));
   assign unit_opa   = gen_next;
   assign unit_opb   = (kind_ff == KIND_INT) ? ({1'b0, diff} + 33'd1) : {1'b0, diff};

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      slot_in      = slot_ff;
      gen_in       = gen_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unit_cmd.start = 1'b0;
      unit_cmd.op    = (kind_ff == KIND_INT) ? OP_MOD : OP_MUL;
      finish = 1'b0;
      val    = lo_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               kind_in   = kind_type'(req_tuser[1:0]);
               lo_in     = req_tdata[31:0];
               hi_in     = req_tdata[63:32];
               slot_in   = 1'b0;
               second_in = 32'd0;
               if (req_tuser[2]) begin
                  gen_in = load_seed(seed_value);
               end
               state_in = S_DRAW;
            end
         end
         S_DRAW: begin
            if (kind_ff == KIND_BOOL) begin
               gen_in = gen_next;
               val    = {31'd0, gen_next[TOP_BIT]};
               finish = 1'b1;
            end else if (empty) begin
               val    = lo_ff;
               finish = 1'b1;
            end else begin
               gen_in         = gen_next;
               unit_cmd.start = 1'b1;
               state_in       = S_WAIT;
            end
         end
         S_WAIT: begin
            if (unit_status.done) begin
               val    = lo_ff + unit_result;
               finish = 1'b1;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_data_in  = {second_ff, first_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         if (slot_ff) begin
            second_in = val;
         end else begin
            first_in = val;
         end
         if ((kind_ff == KIND_PAIR) && !slot_ff) begin
            slot_in  = 1'b1;
            state_in = S_DRAW;
         end else begin
            state_in = S_OUT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kind_ff      <= KIND_BOOL;
         slot_ff      <= 1'b0;
         gen_ff       <= ZERO_SEED_SUBST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         slot_ff      <= slot_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      first_ff    <= first_in;
      second_ff   <= second_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_gen_nonzero: assert property (@(posedge clock) disable iff (reset)
      gen_ff != 32'd0)
      else $error("generator state is zero");

   a_unit_idle_when_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !unit_status.busy)
      else $error("arithmetic unit busy while accepting a request");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      unit_status.done |-> (state_ff == S_WAIT))
      else $error("arithmetic unit finished outside the wait state");

   a_start_from_draw: assert property (@(posedge clock) disable iff (reset)
      unit_cmd.start |-> (state_ff == S_DRAW) && !empty && (kind_ff != KIND_BOOL))
      else $error("arithmetic unit started for a value that needs no draw");

endmodule

/* design/xrvg_csr.sv */
module xrvg_csr
   import xrvg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [31:0] seed_value
);

   localparam logic REG_SEED = 1'b0;

   logic [31:0] seed_ff;
   logic [31:0] seed_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      seed_in = seed_ff;
      if (wr_en && (csr_paddr[2] == REG_SEED)) begin
         seed_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 32'd0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_SEED) ? seed_ff : 32'd0;
   assign seed_value = seed_ff;

endmodule

/* design/xrvg_unit.sv */
module xrvg_unit
   import xrvg_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  unit_cmd_type    cmd,
   input  logic [31:0]     opa,
   input  logic [32:0]     opb,
   output unit_status_type status,
   output logic [31:0]     result
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   op_type      op_ff, op_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [33:0] acc_ff, acc_in;
   logic [31:0] mq_ff, mq_in;
   logic [32:0] b_ff, b_in;

   logic        sub;
   logic [33:0] a_op;
   logic [33:0] b_op;
   logic [34:0] sum;
   logic [32:0] mul_s;

   // one shared adder: trial subtract for remainder, conditional add for product
   always_comb begin
      sub  = (op_ff == OP_MOD);
      a_op = sub ? {acc_ff[32:0], mq_ff[31]} : {2'b00, acc_ff[31:0]};
      b_op = {1'b0, b_ff};
      sum  = {1'b0, a_op} + {1'b0, (sub ? ~b_op : b_op)} + {34'd0, sub};
      mul_s = mq_ff[0] ? sum[32:0] : {1'b0, acc_ff[31:0]};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      mq_in   = mq_ff;
      b_in    = b_ff;
      if (cmd.start && !busy_ff) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = 5'd0;
         acc_in  = 34'd0;
         mq_in   = opa;
         b_in    = opb;
      end else if (busy_ff) begin
         unique case (op_ff)
            OP_MOD: begin
               acc_in = sum[34] ? sum[33:0] : a_op;
               mq_in  = {mq_ff[30:0], 1'b0};
            end
            OP_MUL: begin
               acc_in = {2'b00, mul_s[32:1]};
               mq_in  = {mul_s[0], mq_ff[31:1]};
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(ITER_COUNT - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_MOD;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mq_ff  <= mq_in;
      b_ff   <= b_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign result      = acc_ff[31:0];

endmodule
